@@ hw/rtl/nllf_pkg.sv @@
// shared types, character codes and helpers for the name list line filter
`timescale 1ns / 1ps

package nllf_pkg;

  localparam int MAX_NAME_LEN = 256;
  localparam int NAME_LEN_W   = $clog2(MAX_NAME_LEN + 1);

  typedef logic [NAME_LEN_W-1:0] name_len_t;

  typedef enum logic [1:0] {
    MODE_WAIT = 2'd0,
    MODE_NAME = 2'd1,
    MODE_SKIP = 2'd2
  } line_mode_t;

  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_MAX_SPACES = 8'hFF;

  function automatic logic is_allowed_char(input logic [7:0] c);
    logic res;
    res = ((c >= 8'h30) && (c <= 8'h39)) ||
          ((c >= 8'h61) && (c <= 8'h7A)) ||
          ((c >= 8'h41) && (c <= 8'h5A)) ||
          (c == CH_DASH)   || (c == CH_USCORE) || (c == CH_COMMA)  ||
          (c == CH_DOT)    || (c == CH_LPAREN) || (c == CH_RPAREN) ||
          (c == CH_LBRACK) || (c == CH_RBRACK);
    return res;
  endfunction

endpackage

@@ hw/rtl/name_list_line_filter.sv @@
// name list line filter: cleans a names file byte stream into name characters
// usage:
//   in channel carries one request per cycle: a data byte (in_req_type 0) or
//   an end-of-data flush (in_req_type 1); a request is taken when in_valid is
//   high and in_stall is low
//   out channel gives at most one name character per request, with the count
//   of kept spaces before it, a last-of-name flag and a truncation flag
//   each character is held back until the next character or line end
//   arrives, so a name's last character leaves on the CR, LF or flush
//   path: a result passes the request register, then the result register,
//   before it shows on out_valid
//   throughput: one request per cycle while the receiver does not stall; the
//   per-line state loop is compare and small counter logic
//   receiver stall: the result register holds, the request register fills,
//   then in_stall rises until the result is taken
//   reset: synchronous, active low; clears the valid bits of both registers and all line state
//   names longer than MAX_NAME_LEN lose the excess and flag truncation
`timescale 1ns / 1ps

module name_list_line_filter
  import nllf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_name_char,
  output logic [7:0] out_spaces_before,
  output logic       out_last_of_name,
  output logic       out_name_truncated
);

  localparam name_len_t MAX_LEN = NAME_LEN_W'(MAX_NAME_LEN);

  // request register
  logic       req_valid_r;
  logic       req_type_r;
  logic [7:0] req_byte_r;

  // line state
  line_mode_t mode_r, mode_nxt;
  logic [7:0] held_char_r, held_char_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [7:0] held_spaces_r, held_spaces_nxt;
  logic [7:0] pend_spaces_r, pend_spaces_nxt;
  name_len_t  name_len_r, name_len_nxt;
  logic       ovf_r, ovf_nxt;

  // result register
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic [7:0] out_spaces_r;
  logic       out_last_r;
  logic       out_trunc_r;

  logic emit;
  logic emit_last;
  logic advance;
  logic is_end;
  logic allowed;

  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = req_valid_r && !advance;

  assign is_end  = (req_type_r == REQ_FLUSH) || (req_byte_r == CH_LF) ||
                   (req_byte_r == CH_CR);
  assign allowed = is_allowed_char(req_byte_r);

  always_comb begin
    mode_nxt        = mode_r;
    held_char_nxt   = held_char_r;
    held_valid_nxt  = held_valid_r;
    held_spaces_nxt = held_spaces_r;
    pend_spaces_nxt = pend_spaces_r;
    name_len_nxt    = name_len_r;
    ovf_nxt         = ovf_r;
    emit            = 1'b0;
    emit_last       = 1'b0;
    if (is_end) begin
      emit            = held_valid_r;
      emit_last       = 1'b1;
      mode_nxt        = MODE_WAIT;
      held_char_nxt   = '0;
      held_valid_nxt  = 1'b0;
      held_spaces_nxt = '0;
      pend_spaces_nxt = '0;
      name_len_nxt    = '0;
      ovf_nxt         = 1'b0;
    end else begin
      unique case (mode_r)
        MODE_NAME: begin
          if (allowed) begin
            if (name_len_r < MAX_LEN) begin
              emit            = held_valid_r;
              held_char_nxt   = req_byte_r;
              held_valid_nxt  = 1'b1;
              held_spaces_nxt = pend_spaces_r;
              pend_spaces_nxt = '0;
              name_len_nxt    = name_len_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (req_byte_r == CH_SPACE) begin
            if ((name_len_r < MAX_LEN) && (pend_spaces_r < CH_MAX_SPACES)) begin
              pend_spaces_nxt = pend_spaces_r + 8'd1;
              name_len_nxt    = name_len_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
        MODE_SKIP: begin
        end
        default: begin
          if (allowed) begin
            held_char_nxt   = req_byte_r;
            held_valid_nxt  = 1'b1;
            held_spaces_nxt = '0;
            pend_spaces_nxt = '0;
            name_len_nxt    = NAME_LEN_W'(1);
            mode_nxt        = MODE_NAME;
          end else if (req_byte_r == CH_HASH) begin
            mode_nxt = MODE_SKIP;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (!in_stall) begin
      req_valid_r <= in_valid;
    end
    if (!in_stall) begin
      req_type_r <= in_req_type;
      req_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_WAIT;
      held_char_r   <= '0;
      held_valid_r  <= 1'b0;
      held_spaces_r <= '0;
      pend_spaces_r <= '0;
      name_len_r    <= '0;
      ovf_r         <= 1'b0;
    end else if (req_valid_r && advance) begin
      mode_r        <= mode_nxt;
      held_char_r   <= held_char_nxt;
      held_valid_r  <= held_valid_nxt;
      held_spaces_r <= held_spaces_nxt;
      pend_spaces_r <= pend_spaces_nxt;
      name_len_r    <= name_len_nxt;
      ovf_r         <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= req_valid_r && emit;
    end
    if (advance) begin
      out_char_r   <= held_char_r;
      out_spaces_r <= held_spaces_r;
      out_last_r   <= emit_last;
      out_trunc_r  <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_name_char      = out_char_r;
  assign out_spaces_before  = out_spaces_r;
  assign out_last_of_name   = out_last_r;
  assign out_name_truncated = out_trunc_r;

endmodule

@@ hw/rtl/nllf_checker.sv @@
// port-level checks for the name list line filter, bound to the top level
`timescale 1ns / 1ps

module nllf_assert_checker
  import nllf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_name_char,
  input logic [7:0] out_spaces_before,
  input logic       out_last_of_name
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_name_char) && $stable(out_spaces_before) &&
                               $stable(out_last_of_name))
    else $error("result payload changed while stalled");

  // only cleaned name characters ever leave the block
  a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> is_allowed_char(out_name_char))
    else $error("disallowed character emitted");

  // reset empties the result register
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind name_list_line_filter nllf_assert_checker u_nllf_checker (.*);

@@ verif/nllf_checker.sv @@
// checker for the name list line filter: predicts name characters and compares results
`timescale 1ns / 1ps

module nllf_checker
  import nllf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_data_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_name_char,
  input  logic [7:0] out_spaces_before,
  input  logic       out_last_of_name,
  input  logic       out_name_truncated,
  output int         fail_count,
  output int         outstanding
);

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] spaces;
    logic       last;
    logic       trunc;
  } name_out_t;

  name_out_t  expected_chars[$];
  int         fails = 0;
  int         waiting = 0;

  line_mode_t mode;
  logic [7:0] held_ch;
  logic       held_v;
  logic [7:0] held_sp;
  logic [7:0] pend_sp;
  name_len_t  len;
  logic       ovf;

  assign fail_count  = fails;
  assign outstanding = waiting;

  function automatic logic name_char_ok(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == CH_DASH) || (c == CH_USCORE) || (c == CH_COMMA) ||
           (c == CH_DOT) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
           (c == CH_LBRACK) || (c == CH_RBRACK);
  endfunction

  task automatic clear_line_state();
    mode    = MODE_WAIT;
    held_ch = '0;
    held_v  = 1'b0;
    held_sp = '0;
    pend_sp = '0;
    len     = '0;
    ovf     = 1'b0;
  endtask

  task automatic release_held(input logic last);
    name_out_t e;
    e.ch     = held_ch;
    e.spaces = held_sp;
    e.last   = last;
    e.trunc  = ovf;
    expected_chars.push_back(e);
  endtask

  task automatic filter_request(input logic req, input logic [7:0] b);
    if (req == REQ_FLUSH || b == CH_LF || b == CH_CR) begin
      if (held_v) release_held(1'b1);
      clear_line_state();
    end else begin
      case (mode)
        MODE_NAME: begin
          if (name_char_ok(b)) begin
            if (len < MAX_NAME_LEN) begin
              if (held_v) release_held(1'b0);
              held_ch = b;
              held_v  = 1'b1;
              held_sp = pend_sp;
              pend_sp = '0;
              len     = len + 1'b1;
            end else begin
              ovf = 1'b1;
            end
          end else if (b == CH_SPACE) begin
            if (len < MAX_NAME_LEN && pend_sp != CH_MAX_SPACES) begin
              pend_sp = pend_sp + 1'b1;
              len     = len + 1'b1;
            end else begin
              ovf = 1'b1;
            end
          end
        end
        MODE_SKIP: begin
        end
        default: begin
          if (name_char_ok(b)) begin
            held_ch = b;
            held_v  = 1'b1;
            held_sp = '0;
            pend_sp = '0;
            len     = name_len_t'(1);
            mode    = MODE_NAME;
          end else if (b == CH_HASH) begin
            mode = MODE_SKIP;
          end
        end
      endcase
    end
  endtask

  task automatic check_name_char();
    name_out_t got;
    name_out_t e;
    got.ch     = out_name_char;
    got.spaces = out_spaces_before;
    got.last   = out_last_of_name;
    got.trunc  = out_name_truncated;
    if (expected_chars.size() == 0) begin
      $display("%0t: unexpected name char, got ch=%h sp=%0d last=%b trunc=%b",
               $time, got.ch, got.spaces, got.last, got.trunc);
      fails++;
    end else begin
      e = expected_chars.pop_front();
      if (got !== e) begin
        $display("%0t: name char mismatch, expected ch=%h sp=%0d last=%b trunc=%b,",
                 $time, e.ch, e.spaces, e.last, e.trunc,
                 " got ch=%h sp=%0d last=%b trunc=%b",
                 got.ch, got.spaces, got.last, got.trunc);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_line_state();
      expected_chars.delete();
    end else begin
      if (out_valid && !out_stall) check_name_char();
      if (in_valid && !in_stall) filter_request(in_req_type, in_data_byte);
    end
    waiting = expected_chars.size();
  end

endmodule

@@ verif/tb.sv @@
// testbench top for the name list line filter: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb;
  import nllf_pkg::*;

  localparam int N_REQUESTS  = 1850;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 300;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_req_type = REQ_DATA;
  logic [7:0] in_data_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_name_char;
  logic [7:0] out_spaces_before;
  logic       out_last_of_name;
  logic       out_name_truncated;

  int   fail_count;
  int   outstanding;
  int   sent = 0;
  int   cycles = 0;
  logic tx_burst = 1'b0;
  logic rx_burst = 1'b0;
  logic hold_rx = 1'b0;

  name_list_line_filter DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_name_char     (out_name_char),
    .out_spaces_before (out_spaces_before),
    .out_last_of_name  (out_last_of_name),
    .out_name_truncated(out_name_truncated)
  );

  nllf_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_name_char     (out_name_char),
    .out_spaces_before (out_spaces_before),
    .out_last_of_name  (out_last_of_name),
    .out_name_truncated(out_name_truncated),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_req(input logic req, input logic [7:0] b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_data(input logic [7:0] b);
    send_req(REQ_DATA, b);
  endtask

  task automatic send_flush();
    send_req(REQ_FLUSH, 8'($urandom));
  endtask

  function automatic logic [7:0] pick_name_char();
    int k;
    k = $urandom_range(0, 69);
    if (k < 10) return 8'(8'h30 + k);
    if (k < 36) return 8'(8'h41 + k - 10);
    if (k < 62) return 8'(8'h61 + k - 36);
    case (k)
      62:      return CH_DASH;
      63:      return CH_USCORE;
      64:      return CH_COMMA;
      65:      return CH_DOT;
      66:      return CH_LPAREN;
      67:      return CH_RPAREN;
      68:      return CH_LBRACK;
      default: return CH_RBRACK;
    endcase
  endfunction

  function automatic logic [7:0] pick_noise_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_LF || b == CH_CR);
    return b;
  endfunction

  task automatic send_line_end();
    case ($urandom_range(0, 3))
      0: send_data(CH_CR);
      1: send_data(CH_LF);
      2: begin
        send_data(CH_CR);
        send_data(CH_LF);
      end
      default: send_flush();
    endcase
  endtask

  task automatic send_name_line(input int n_chars, input int max_run);
    int i;
    repeat ($urandom_range(0, 3)) send_data(CH_SPACE);
    for (i = 0; i < n_chars; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, max_run)) send_data(CH_SPACE);
      if ($urandom_range(0, 15) == 0) send_data(pick_noise_byte());
      send_data(pick_name_char());
    end
    repeat ($urandom_range(0, 2)) send_data(CH_SPACE);
    send_line_end();
  endtask

  task automatic send_comment_line();
    repeat ($urandom_range(0, 2)) send_data(CH_SPACE);
    send_data(CH_HASH);
    repeat ($urandom_range(0, 8)) send_data(pick_noise_byte());
    send_line_end();
  endtask

  // one char, then more spaces than one count can hold, then a char lost to length
  task automatic send_space_run_line();
    send_data(pick_name_char());
    repeat (270) send_data(CH_SPACE);
    send_data(pick_name_char());
    send_data(CH_LF);
  endtask

  initial begin : receiver
    int w;
    forever begin
      if (hold_rx) begin
        w = LONG_HOLD;
        hold_rx = 1'b0;
      end else begin
        if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
        w = rx_burst ? 0 : $urandom_range(0, 10);
      end
      @(negedge clk);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int  k;
    logic long_names_done;
    logic space_run_done;
    long_names_done = 1'b0;
    space_run_done  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // leading, inner and trailing spaces
    send_data(CH_SPACE); send_data(CH_SPACE); send_data(8'h41); send_data(8'h30);
    send_data(CH_SPACE); send_data(CH_SPACE); send_data(8'h7A); send_data(CH_SPACE);
    send_data(CH_LF);
    // comment line
    send_data(CH_HASH); send_data(8'h41); send_data(CH_CR);
    // hash and high bytes inside a name, closed by flush
    send_data(8'h5A); send_data(CH_HASH); send_data(8'h39); send_data(8'hFF);
    send_data(8'h80); send_data(8'h00); send_flush();
    // every punctuation mark, then empty lines
    send_data(CH_DASH); send_data(CH_USCORE); send_data(CH_COMMA); send_data(CH_DOT);
    send_data(CH_LPAREN); send_data(CH_RPAREN); send_data(CH_LBRACK);
    send_data(CH_RBRACK); send_data(CH_CR); send_data(CH_LF); send_flush();

    while (sent < N_REQUESTS) begin
      if ($urandom_range(0, 9) == 0) tx_burst = !tx_burst;
      if (!long_names_done && sent > 500) begin
        // receiver holds off while names pour in
        tx_burst = 1'b1;
        hold_rx  = 1'b1;
        send_name_line($urandom_range(250, 300), 3);
        send_name_line(MAX_NAME_LEN, 1);
        tx_burst = 1'b0;
        long_names_done = 1'b1;
      end else if (!space_run_done && sent > 1400) begin
        hold_rx = 1'b1;
        send_space_run_line();
        space_run_done = 1'b1;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 60) begin
          send_name_line($urandom_range(1, 12), 3);
        end else if (k < 75) begin
          send_comment_line();
        end else if (k < 90) begin
          repeat ($urandom_range(1, 6)) send_data(8'($urandom));
        end else if (k < 95) begin
          send_flush();
        end else begin
          send_line_end();
        end
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
